// File: rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared widths and request codes for the sorted character table.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int VALUE_W = 8;
  localparam int COUNT_W = 5;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

endpackage

// File: rtl/sorted_char_table.sv
// ----------------------------------------------------------------------------
// sorted_char_table
// Bounded multiset of signed 8-bit values held in ascending order.
//
// Input channel (in_valid/in_ready): in_req_type selects insert or remove of
// in_value. Insert places the value ahead of the first entry not smaller and
// fails when CAPACITY entries are held; remove deletes the lowest-slot equal
// entry and fails when none matches.
// Result channel (out_valid/out_ready): one transaction per request carrying
// out_ok, out_entry_count (count after the operation, low 5 bits) and
// out_smallest (head entry, zero when empty).
// Entries live in a memory with a registered read; each compared or moved
// slot takes a read, then a compare or write. From acceptance, the search
// walks the slots in ascending order up to the first one not smaller (or to
// the count), the shift moves entries one slot at a time, and a head read
// loads out_smallest before out_valid rises; an insert into a full table goes
// straight to the head read. in_ready is high only while the sequencer idles,
// so a new request is taken only after the last result is registered.
// A finished result sits in the output register while the next transaction is
// accepted; if that one finishes first, the sequencer holds until out_ready.
// Reset (rst_n low, synchronous) empties the table; no memory clearing pass.
// ----------------------------------------------------------------------------
module sorted_char_table #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  logic signed [sct_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_ok,
  output logic        [sct_pkg::COUNT_W-1:0]  out_entry_count,
  output logic signed [sct_pkg::VALUE_W-1:0]  out_smallest
);
  import sct_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH_RD,
    ST_SEARCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_HEAD_RD,
    ST_HEAD_OUT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic                       ins_r, ins_nxt;
  logic signed [VALUE_W-1:0]  val_r, val_nxt;
  logic                       ok_r, ok_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_ok_r, out_ok_nxt;
  logic [COUNT_W-1:0]         out_cnt_r, out_cnt_nxt;
  logic signed [VALUE_W-1:0]  out_small_r, out_small_nxt;

  logic signed [VALUE_W-1:0]  mem [CAPACITY];
  logic signed [VALUE_W-1:0]  rd_data_r;
  logic [AW-1:0]              rd_addr;
  logic                       we;
  logic [AW-1:0]              wr_addr;
  logic signed [VALUE_W-1:0]  wr_data;

  logic [CW-1:0]              idx_dec;
  logic [CW:0]                idx_inc;
  logic [CW+COUNT_W-1:0]      cnt_ext;

  assign idx_dec = idx_r - 1'b1;
  assign idx_inc = {1'b0, idx_r} + 1'b1;
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_r};

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_entry_count = out_cnt_r;
  assign out_smallest    = out_small_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    ins_nxt       = ins_r;
    val_nxt       = val_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    out_cnt_nxt   = out_cnt_r;
    out_small_nxt = out_small_r;
    rd_addr       = '0;
    we            = 1'b0;
    wr_addr       = idx_r[AW-1:0];
    wr_data       = rd_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ins_nxt = (in_req_type == REQ_INSERT);
          val_nxt = in_value;
          idx_nxt = '0;
          ok_nxt  = 1'b0;
          if ((in_req_type == REQ_INSERT) && (cnt_r == CW'(CAPACITY))) begin
            state_nxt = ST_HEAD_RD;
          end else begin
            state_nxt = ST_SEARCH_RD;
          end
        end
      end
      ST_SEARCH_RD: begin
        rd_addr = idx_r[AW-1:0];
        if (idx_r == cnt_r) begin
          if (ins_r) begin
            idx_nxt   = cnt_r;
            state_nxt = ST_SHIFT_RD;
          end else begin
            state_nxt = ST_HEAD_RD;
          end
        end else begin
          state_nxt = ST_SEARCH_CMP;
        end
      end
      ST_SEARCH_CMP: begin
        if (rd_data_r < val_r) begin
          idx_nxt   = idx_inc[CW-1:0];
          state_nxt = ST_SEARCH_RD;
        end else if (ins_r) begin
          ok_nxt    = 1'b0;
          idx_nxt   = cnt_r;
          state_nxt = ST_SHIFT_RD;
        end else if (rd_data_r == val_r) begin
          state_nxt = ST_SHIFT_RD;
        end else begin
          state_nxt = ST_HEAD_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (ins_r) begin
          rd_addr = idx_dec[AW-1:0];
          // ok_r marks the insert slot once the walk down reaches it
          if (ok_r) begin
            we        = 1'b1;
            wr_data   = val_r;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = ST_HEAD_RD;
          end else begin
            state_nxt = ST_SHIFT_WR;
          end
        end else begin
          rd_addr = idx_inc[AW-1:0];
          if (idx_inc >= {1'b0, cnt_r}) begin
            ok_nxt    = 1'b1;
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = ST_HEAD_RD;
          end else begin
            state_nxt = ST_SHIFT_WR;
          end
        end
      end
      ST_SHIFT_WR: begin
        we        = 1'b1;
        idx_nxt   = ins_r ? idx_dec : idx_inc[CW-1:0];
        state_nxt = ST_SHIFT_RD;
      end
      ST_HEAD_RD: begin
        state_nxt = ST_HEAD_OUT;
      end
      ST_HEAD_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_cnt_nxt   = cnt_ext[COUNT_W-1:0];
          out_small_nxt = (cnt_r != '0) ? rd_data_r : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Insert: the search result position is tracked in pos_r; ok_r flags arrival.
  logic [CW-1:0] pos_r, pos_nxt;

  always_comb begin
    pos_nxt = pos_r;
    if ((state_r == ST_SEARCH_RD) && (idx_r == cnt_r)) begin
      pos_nxt = cnt_r;
    end else if ((state_r == ST_SEARCH_CMP) && !(rd_data_r < val_r)) begin
      pos_nxt = idx_r;
    end
  end

  logic ins_hit;
  assign ins_hit = ins_r && (idx_nxt == pos_nxt) &&
                   ((state_nxt == ST_SHIFT_RD) && (state_r != ST_HEAD_RD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (ins_r && (state_nxt == ST_SHIFT_RD)) begin
        ok_r <= ins_hit;
      end else begin
        ok_r <= ok_nxt;
      end
    end
    idx_r       <= idx_nxt;
    ins_r       <= ins_nxt;
    val_r       <= val_nxt;
    pos_r       <= pos_nxt;
    out_ok_r    <= out_ok_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_small_r <= out_small_nxt;
  end

endmodule
